// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SITD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define SITD_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/sitd_pkg.sv =====
// shared types, constants and helper function for the decimal text converter
`default_nettype none
package sitd_pkg;

  localparam int VALUE_W        = 32;
  localparam int WIDTH_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int NUM_DIGITS     = 10;
  localparam int BCD_W          = 4 * NUM_DIGITS;
  localparam int WORK_W         = BCD_W + VALUE_W;
  localparam int LEN_W          = 4;
  localparam int STEPS_PER_STG  = 4;
  localparam int NUM_DAB_STG    = VALUE_W / STEPS_PER_STG;
  localparam int MAX_WIDTH_DEF  = 32;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

  typedef struct packed {
    logic               negative;
    logic [WIDTH_W-1:0] width;
    logic [WORK_W-1:0]  work;
  } sitd_pipe_t;

  typedef struct packed {
    logic               negative;
    logic [LEN_W-1:0]   text_len;
    logic [WIDTH_W-1:0] total;
    logic [BCD_W-1:0]   bcd;
  } sitd_item_t;

  // one shift-and-add-3 step: bcd digits sit above the binary part
  function automatic logic [WORK_W-1:0] dabble_step(input logic [WORK_W-1:0] w);
    logic [WORK_W-1:0] t;
    t = w;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (t[VALUE_W+4*i +: 4] >= 4'd5) begin
        t[VALUE_W+4*i +: 4] = t[VALUE_W+4*i +: 4] + 4'd3;
      end
    end
    return {t[WORK_W-2:0], 1'b0};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sitd_conv.sv =====
// pipelined magnitude to bcd conversion with text length computation
`default_nettype none
module sitd_conv #(
  parameter int MAX_WIDTH = sitd_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sitd_pkg::VALUE_W-1:0]      value_i,
  input  logic [sitd_pkg::WIDTH_W-1:0]      min_width_i,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output sitd_pkg::sitd_item_t              item_o
);
  import sitd_pkg::*;

  localparam int NS = NUM_DAB_STG;

  logic [NS:0]   vld_q;
  logic [NS+1:0] en;
  sitd_pipe_t    pipe_d [NS+1];
  sitd_pipe_t    pipe_q [NS+1];
  logic          item_vld_q;
  sitd_item_t    item_d;
  sitd_item_t    item_q;

  // stage 0: magnitude and width saturation
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [WIDTH_W-1:0] wsat;

  always_comb begin
    neg  = value_i[VALUE_W-1];
    mag  = neg ? (VALUE_W'(0) - value_i) : value_i;
    wsat = ({1'b0, min_width_i} > (WIDTH_W+1)'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                          : min_width_i;
    pipe_d[0].negative = neg;
    pipe_d[0].width    = wsat;
    pipe_d[0].work     = {{BCD_W{1'b0}}, mag};
  end

  genvar g;
  generate
    for (g = 1; g <= NS; g++) begin : g_dab
      always_comb begin
        pipe_d[g] = pipe_q[g-1];
        for (int s = 0; s < STEPS_PER_STG; s++) begin
          pipe_d[g].work = dabble_step(pipe_d[g].work);
        end
      end
    end
    for (g = 0; g <= NS; g++) begin : g_en
      assign en[g] = !vld_q[g] || en[g+1];
    end
  endgenerate

  assign en[NS+1] = !item_vld_q || item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i <= NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= NS; i++) begin
      if (en[i]) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

  // final stage: digit count and total character count
  logic [LEN_W-1:0] nd;
  logic [BCD_W-1:0] bcd;
  always_comb begin
    bcd = pipe_q[NS].work[WORK_W-1 -: BCD_W];
    nd  = LEN_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        nd = LEN_W'(i + 1);
      end
    end
    item_d.negative = pipe_q[NS].negative;
    item_d.bcd      = bcd;
    item_d.text_len = nd + LEN_W'(pipe_q[NS].negative);
    item_d.total    = (pipe_q[NS].width > WIDTH_W'(item_d.text_len)) ? pipe_q[NS].width
                                                                      : WIDTH_W'(item_d.text_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (en[NS+1]) begin
      item_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS+1]) begin
      item_q <= item_d;
    end
  end

  assign in_ready_o   = en[0];
  assign item_valid_o = item_vld_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_decimal_text_top.sv =====
// top level: signed integer to space-padded decimal ascii text stream
// An input beat (value, min_width) comes out as one output beat per character,
// most significant first, with tlast on the final one. A new input beat can be
// taken every cycle while the pipeline is not stalled by output back-pressure,
// into a ten-stage conversion pipeline (abs and width clamp, eight
// shift-and-add-3 stages of four bits each, digit count). Sustained rate is set
// by the single-character output port: an item is max(text length, width)
// characters long with the width clamped to MAX_WIDTH, so 1 to 32 with the
// default; text length is 1 to 11.
`default_nettype none
module signed_int_to_decimal_text_top #(
  parameter int MAX_WIDTH = sitd_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [37:32] min_width, [39:38] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero
  output logic        m_axis_tlast
);
  import sitd_pkg::*;

  logic       item_vld;
  logic       item_rdy;
  sitd_item_t item;

  sitd_conv #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .value_i      (s_axis_tdata[VALUE_W-1:0]),
    .min_width_i  (s_axis_tdata[VALUE_W +: WIDTH_W]),
    .item_valid_o (item_vld),
    .item_ready_i (item_rdy),
    .item_o       (item)
  );

  // serializer: walks one item out a character at a time
  logic               sr_vld_q, sr_vld_d;
  sitd_item_t         sr_q, sr_d;
  logic [WIDTH_W-1:0] pos_q, pos_d;
  logic               m_vld_q, m_vld_d;
  logic [CHAR_W-1:0]  m_chr_q, m_chr_d;
  logic               m_last_q, m_last_d;

  logic               out_free;
  logic               emit;
  logic               last_char;
  logic [WIDTH_W-1:0] pad;
  logic [WIDTH_W-1:0] dig_idx;
  logic [3:0]         dig;
  logic [CHAR_W-1:0]  chr;

  always_comb begin
    out_free  = !m_vld_q || m_axis_tready;
    emit      = sr_vld_q && out_free;
    last_char = (pos_q == sr_q.total - WIDTH_W'(1));
    pad       = sr_q.total - WIDTH_W'(sr_q.text_len);
    dig_idx   = sr_q.total - WIDTH_W'(1) - pos_q;
    dig       = 4'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (dig_idx == WIDTH_W'(i)) begin
        dig = sr_q.bcd[4*i +: 4];
      end
    end
    if (pos_q < pad) begin
      chr = CH_SPACE;
    end else if (sr_q.negative && (pos_q == pad)) begin
      chr = CH_MINUS;
    end else begin
      chr = CH_ZERO + CHAR_W'(dig);
    end
  end

  assign item_rdy = !sr_vld_q || (emit && last_char);

  always_comb begin
    sr_vld_d = sr_vld_q;
    sr_d     = sr_q;
    pos_d    = pos_q;
    if (item_rdy) begin
      sr_vld_d = item_vld;
      sr_d     = item;
      pos_d    = '0;
    end else if (emit) begin
      pos_d = pos_q + WIDTH_W'(1);
    end
  end

  always_comb begin
    m_vld_d  = m_vld_q;
    m_chr_d  = m_chr_q;
    m_last_d = m_last_q;
    if (emit) begin
      m_vld_d  = 1'b1;
      m_chr_d  = chr;
      m_last_d = last_char;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_vld_q <= 1'b0;
      pos_q    <= '0;
      m_vld_q  <= 1'b0;
    end else begin
      sr_vld_q <= sr_vld_d;
      pos_q    <= pos_d;
      m_vld_q  <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q     <= sr_d;
    m_chr_q  <= m_chr_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {1'b0, m_chr_q};
  assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire

// ===== rtl/sitd_checker.sv =====
// port-level checks for the decimal text converter, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sitd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [39:0] s_axis_tdata,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire        m_axis_tlast
);
  import sitd_pkg::*;

  // a stalled output beat stays offered
  `SITD_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output beat dropped while stalled")

  // only space, minus or a digit ever leaves
  `SITD_ASSERT(a_char_legal, clk_i, rst_ni, m_axis_tvalid |-> ((m_axis_tdata[6:0] == CH_SPACE) || (m_axis_tdata[6:0] == CH_MINUS) || ((m_axis_tdata[6:0] >= CH_ZERO) && (m_axis_tdata[6:0] <= CH_ZERO + 7'd9))), "illegal character")

  // text always ends in a digit, so padding or a sign is never last
  `SITD_NEVER(a_last_digit, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast && ((m_axis_tdata[6:0] == CH_SPACE) || (m_axis_tdata[6:0] == CH_MINUS)), "last beat is not a digit")

  // a minus sign is always followed by a digit
  `SITD_ASSERT(a_minus_then_digit, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready && (m_axis_tdata[6:0] == CH_MINUS)) |=> (!m_axis_tvalid || (m_axis_tdata[6:0] != CH_SPACE && m_axis_tdata[6:0] != CH_MINUS)), "minus sign not followed by digit")

endmodule

bind signed_int_to_decimal_text_top sitd_checker u_sitd_checker (.*);
`default_nettype wire
